[src/aft_pkg.sv]
// Shared constants, codes and types for the animation frame timer.
package aft_pkg;

  // Sizing
  localparam int MAX_FRAMES = 16;
  localparam int TIME_W     = 32;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int FC_W       = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int CMD_W      = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_EN     = CFG_IDX_W'(1);

  // Item commands
  localparam logic [CMD_W-1:0] CMD_LOAD   = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_TICK   = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_SELECT = CMD_W'(2);

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_APPLY,
    S_EMIT
  } state_t;

  // Datapath operation issued each cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_EXEC,
    OP_WALK,
    OP_APPLY,
    OP_EMIT
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic walk_start;  // enabled tick that overruns the time left
    logic walk_stop;   // walk ends this cycle
    logic walk_full;   // walk came back round to the visible frame
    logic out_free;    // result register can take a beat
  } dp_status_t;

endpackage

[src/aft_ifs.sv]
// Request and response channel interfaces for the animation frame timer.
interface aft_req_if import aft_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [FRAME_W-1:0]   frame_index;
  logic [TIME_W-1:0]    delay_ms;
  logic [TIME_W-1:0]    elapsed_ms;

  modport source (output valid, cmd, frame_index, delay_ms, elapsed_ms, input ready);
  modport sink   (input valid, cmd, frame_index, delay_ms, elapsed_ms, output ready);
endinterface

interface aft_rsp_if import aft_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FRAME_W-1:0]   visible_frame;
  logic [TIME_W-1:0]    time_left;
  logic                 frame_changed;

  modport source (output valid, visible_frame, time_left, frame_changed, input ready);
  modport sink   (input valid, visible_frame, time_left, frame_changed, output ready);
endinterface

[src/aft_dp.sv]
// Datapath: delay table, frame and time state, walk registers, result register.
module aft_dp import aft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      in_cmd,
  input  logic [FRAME_W-1:0]    in_frame_index,
  input  logic [TIME_W-1:0]     in_delay_ms,
  input  logic [TIME_W-1:0]     in_elapsed_ms,
  input  dp_op_t                op,
  output dp_status_t            status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRAME_W-1:0]    out_visible_frame,
  output logic [TIME_W-1:0]     out_time_left,
  output logic                  out_frame_changed
);

  // Configuration
  logic [FC_W-1:0]    frame_count;
  logic               anim_en;

  // Stored state
  logic [TIME_W-1:0]  delay_table [MAX_FRAMES];
  logic [FRAME_W-1:0] shown;
  logic [TIME_W-1:0]  rem;

  // Captured item and walk registers
  logic [CMD_W-1:0]   cmd;
  logic [FRAME_W-1:0] idx;
  logic [TIME_W-1:0]  dly;
  logic [TIME_W-1:0]  el;
  logic [FRAME_W-1:0] pos;
  logic [CNT_W-1:0]   n;
  logic [TIME_W-1:0]  left;
  logic               chg;

  logic [CNT_W-1:0]   fc_eff;
  logic [CNT_W-1:0]   pos_inc;
  logic [FRAME_W-1:0] pos_nx;
  logic [CNT_W-1:0]   n_inc;
  logic [FRAME_W-1:0] rd_addr;
  logic [TIME_W-1:0]  rd_data;
  logic [TIME_W-1:0]  el_sub;
  logic               full;
  logic               brk;
  logic               sel_ok;

  // Effective frame count: zero acts as one, clamp at the table size
  always_comb begin
    if (frame_count == '0) begin
      fc_eff = CNT_W'(1);
    end else if (32'(frame_count) > MAX_FRAMES) begin
      fc_eff = CNT_W'(MAX_FRAMES);
    end else begin
      fc_eff = CNT_W'(frame_count);
    end
  end

  // Walk step: next frame with wrap, one table read, one subtract and compare
  assign pos_inc = CNT_W'(pos) + CNT_W'(1);
  assign pos_nx  = (pos_inc >= fc_eff) ? '0 : pos_inc[FRAME_W-1:0];
  assign n_inc   = n + CNT_W'(1);
  assign full    = (n_inc >= fc_eff);
  assign rd_addr = (op == OP_WALK) ? pos_nx : idx;
  assign rd_data = delay_table[rd_addr];
  assign el_sub  = el - left;
  assign brk     = (el_sub <= rd_data);
  assign sel_ok  = (CNT_W'(idx) < fc_eff);

  // Status to the controller
  assign status.walk_start = (cmd == CMD_TICK) && anim_en && (el > rem);
  assign status.walk_stop  = full || brk;
  assign status.walk_full  = full;
  assign status.out_free   = !out_valid || out_ready;

  // Delay table, written on load
  always_ff @(posedge clk) begin
    if (op == OP_EXEC && cmd == CMD_LOAD) begin
      delay_table[idx] <= dly;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FC_W'(1);
      anim_en     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_COUNT: frame_count <= cfg_data[FC_W-1:0];
        REG_ANIM_EN:     anim_en     <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  // Frame state and walk
  always_ff @(posedge clk) begin
    if (rst) begin
      shown <= '0;
      rem   <= '0;
    end else begin
      case (op)
        OP_CAPTURE: begin
          cmd <= in_cmd;
          idx <= in_frame_index;
          dly <= in_delay_ms;
          el  <= in_elapsed_ms;
        end
        OP_EXEC: begin
          chg <= 1'b0;
          case (cmd)
            CMD_SELECT: begin
              if (sel_ok) begin
                chg   <= (shown != idx);
                shown <= idx;
                rem   <= rd_data;
              end
            end
            CMD_TICK: begin
              if (anim_en) begin
                if (el > rem) begin
                  pos  <= shown;
                  n    <= '0;
                  left <= rem;
                end else begin
                  rem <= rem - el;
                end
              end
            end
            default: ;
          endcase
        end
        OP_WALK: begin
          // Full cycle keeps the frame and takes the last delay examined
          if (full) begin
            rem <= left;
          end else begin
            el   <= el_sub;
            pos  <= pos_nx;
            left <= rd_data;
            n    <= n_inc;
          end
        end
        OP_APPLY: begin
          shown <= pos;
          rem   <= left - el;
          chg   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      out_visible_frame <= shown;
      out_time_left     <= rem;
      out_frame_changed <= chg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Checks
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT) |=> out_valid)
    else $error("result register not valid after emit");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (op == OP_WALK) |-> (n < fc_eff))
    else $error("walk step count reached the frame count");

  a_apply_frame: assert property (@(posedge clk) disable iff (rst)
    (op == OP_APPLY) |=> (chg && shown == $past(pos)))
    else $error("apply did not select the walked frame");

  a_fc_range: assert property (@(posedge clk) disable iff (rst)
    (fc_eff != '0) && (32'(fc_eff) <= MAX_FRAMES))
    else $error("effective frame count out of range");

endmodule

[src/aft_ctrl.sv]
// Controller: sequences capture, execute, frame walk and result beat.
module aft_ctrl import aft_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath operation
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_CAPTURE;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        op         = OP_EXEC;
        state_next = status.walk_start ? S_WALK : S_EMIT;
      end
      S_WALK: begin
        op = OP_WALK;
        if (status.walk_stop) begin
          state_next = status.walk_full ? S_EMIT : S_APPLY;
        end
      end
      S_APPLY: begin
        op         = OP_APPLY;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/animation_frame_timer.sv]
// Animation frame timer top level: channels, configuration port, controller and datapath.
//
// Steps a sprite through a cycle of up to 16 frames, each shown for its own delay from a
// table filled by load beats. Every request beat gives exactly one response beat. Load,
// select, disabled ticks and ticks that fit in the time left pass through capture,
// execute and emit. A tick that overruns the time left walks the frames one per cycle,
// since the delay table has a single read port and each step does one subtract and
// compare; after the walk an apply step shows the new frame, unless the walk came back
// round to the visible frame. The response sits in an output register, so the next
// request is taken while a result waits. Configuration is written through cfg_we /
// cfg_index / cfg_data; the user must write it only while the block is idle, which the block itself does not enforce.
module animation_frame_timer import aft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  aft_req_if.sink               req,
  aft_rsp_if.source             rsp
);

  dp_op_t     op;
  dp_status_t status;

  // Sequencer
  aft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .op       (op)
  );

  // Datapath
  aft_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_cmd            (req.cmd),
    .in_frame_index    (req.frame_index),
    .in_delay_ms       (req.delay_ms),
    .in_elapsed_ms     (req.elapsed_ms),
    .op                (op),
    .status            (status),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_visible_frame (rsp.visible_frame),
    .out_time_left     (rsp.time_left),
    .out_frame_changed (rsp.frame_changed)
  );

endmodule

[bench/tb.sv]
// Testbench for the animation frame timer: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import aft_pkg::*;

  // cmd value that the block treats as a no-op
  localparam logic [CMD_W-1:0] CMD_NOP = CMD_W'(3);

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [FRAME_W-1:0] frame_index;
    logic [TIME_W-1:0]  delay_ms;
    logic [TIME_W-1:0]  elapsed_ms;
  } frame_cmd_t;

  typedef struct packed {
    logic [FRAME_W-1:0] visible_frame;
    logic [TIME_W-1:0]  time_left;
    logic               frame_changed;
  } frame_view_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  aft_req_if req_ch ();
  aft_rsp_if rsp_ch ();

  animation_frame_timer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Clock: 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predicted block state
  logic [TIME_W-1:0]  delay_mem [MAX_FRAMES];
  logic [FRAME_W-1:0] cur_frame;
  logic [TIME_W-1:0]  cur_left;
  logic [FC_W-1:0]    fc_reg;
  logic               anim_on;

  frame_view_t pending_views[$];
  int          mismatches   = 0;
  int          sent_items   = 0;
  int          stall_left   = 0;
  bit          quiet        = 1'b0;

  function automatic int clamp_count();
    int f;
    f = fc_reg;
    if (f == 0) f = 1;
    if (f > MAX_FRAMES) f = MAX_FRAMES;
    return f;
  endfunction

  // Apply one beat to the predicted state and return the view it should produce
  function automatic frame_view_t step_timer(input frame_cmd_t c);
    int                fc;
    int                pos;
    int                steps;
    logic [TIME_W-1:0] el;
    logic [TIME_W-1:0] left;
    bit                changed;
    bit                full_lap;
    frame_view_t       v;
    fc       = clamp_count();
    el       = c.elapsed_ms;
    changed  = 1'b0;
    full_lap = 1'b0;
    case (c.cmd)
      CMD_LOAD: begin
        delay_mem[c.frame_index] = c.delay_ms;
      end
      CMD_SELECT: begin
        if (int'(c.frame_index) < fc) begin
          changed   = (cur_frame != c.frame_index);
          cur_frame = c.frame_index;
          cur_left  = delay_mem[c.frame_index];
        end
      end
      CMD_TICK: begin
        if (anim_on) begin
          if (el > cur_left) begin
            // walk forward spending each frame's delay until the rest fits
            pos   = cur_frame;
            steps = 0;
            left  = cur_left;
            while (1) begin
              steps++;
              if (steps >= fc) begin
                full_lap = 1'b1;
                break;
              end
              el  -= left;
              pos++;
              if (pos >= fc) pos = 0;
              left = delay_mem[pos];
              if (el <= left) break;
            end
            if (full_lap) begin
              cur_left = left;
            end else begin
              cur_frame = FRAME_W'(pos);
              cur_left  = left - el;
              changed   = 1'b1;
            end
          end else begin
            cur_left = cur_left - el;
          end
        end
      end
      default: ;
    endcase
    v.visible_frame = cur_frame;
    v.time_left     = cur_left;
    v.frame_changed = changed;
    return v;
  endfunction

  // Gap length: mostly none or short, a few long; none while quiet
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic frame_cmd_t make_cmd(logic [CMD_W-1:0] op, int idx,
                                          logic [TIME_W-1:0] dly, logic [TIME_W-1:0] el);
    frame_cmd_t c;
    c.cmd         = op;
    c.frame_index = FRAME_W'(idx);
    c.delay_ms    = dly;
    c.elapsed_ms  = el;
    return c;
  endfunction

  function automatic frame_cmd_t random_cmd();
    int         r;
    int         fc;
    frame_cmd_t c;
    fc = clamp_count();
    r  = $urandom_range(0, 99);
    c.cmd = (r < 25) ? CMD_LOAD : (r < 68) ? CMD_TICK : (r < 96) ? CMD_SELECT : CMD_NOP;
    c.frame_index = FRAME_W'($urandom_range(0, MAX_FRAMES - 1));
    if (c.cmd == CMD_SELECT && $urandom_range(0, 6) != 0)
      c.frame_index = FRAME_W'($urandom_range(0, fc - 1));
    r = $urandom_range(0, 99);
    c.delay_ms = (r < 70) ? $urandom_range(0, 500) : (r < 85) ? $urandom_range(0, 20) : $urandom;
    // elapsed time: fits, overruns by a little, tiny, or anything
    r = $urandom_range(0, 99);
    if (r < 30)      c.elapsed_ms = $urandom_range(0, cur_left);
    else if (r < 75) c.elapsed_ms = cur_left + $urandom_range(1, 1500);
    else if (r < 85) c.elapsed_ms = $urandom_range(0, 50);
    else             c.elapsed_ms = $urandom;
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Drive one request beat; valid stays high afterwards unless a gap follows
  task automatic send_cmd(frame_cmd_t c);
    int          gap;
    frame_view_t v;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= c.cmd;
    req_ch.frame_index <= c.frame_index;
    req_ch.delay_ms    <= c.delay_ms;
    req_ch.elapsed_ms  <= c.elapsed_ms;
    do @(posedge clk); while (!req_ch.ready);
    v = step_timer(c);
    pending_views.push_back(v);
    sent_items++;
  endtask

  // Drop valid and wait at least one edge, then until every result is back
  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_views.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_COUNT) fc_reg = data[FC_W-1:0];
    else if (idx == REG_ANIM_EN) anim_on = data[0];
  endtask

  // Fill the whole delay table under reset config; ticks are still disabled here
  task automatic test_table_fill();
    logic [TIME_W-1:0] d;
    send_cmd(make_cmd(CMD_TICK, 0, 0, 32'd7));
    for (int i = 0; i < MAX_FRAMES; i++) begin
      d = (i == 5) ? 32'd0 : (i == 15) ? 32'hFFFF_FFFF : (i == 10) ? 32'h8000_0000
                   : 32'(100 * (i + 1));
      send_cmd(make_cmd(CMD_LOAD, i, d, $urandom));
    end
  endtask

  // Selects, ticks that fit, walks, wraps, full laps and count corner cases
  task automatic test_directed_walks();
    wait_results_drained();
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(4));
    write_reg(REG_ANIM_EN, CFG_DATA_W'(1));
    send_cmd(make_cmd(CMD_SELECT, 0, 0, 0));       // current frame, reload only
    send_cmd(make_cmd(CMD_SELECT, 2, 0, 0));
    send_cmd(make_cmd(CMD_SELECT, 4, 0, 0));       // out of range
    send_cmd(make_cmd(CMD_TICK, 0, 0, 0));
    send_cmd(make_cmd(CMD_TICK, 0, 0, 300));       // exactly the time left
    send_cmd(make_cmd(CMD_TICK, 0, 0, 250));       // one step forward
    send_cmd(make_cmd(CMD_TICK, 0, 0, 550));       // wraps past the count
    send_cmd(make_cmd(CMD_TICK, 0, 0, 32'hFFFF_FFFF)); // comes back round
    send_cmd(make_cmd(CMD_NOP, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    wait_results_drained();
    write_reg(REG_ANIM_EN, CFG_DATA_W'(0));
    send_cmd(make_cmd(CMD_TICK, 0, 0, 32'd5));     // disabled
    // visible frame left beyond a lowered count
    wait_results_drained();
    write_reg(REG_ANIM_EN, CFG_DATA_W'(1));
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(2));
    send_cmd(make_cmd(CMD_TICK, 0, 0, cur_left + 32'd50));
    wait_results_drained();
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(1));
    send_cmd(make_cmd(CMD_TICK, 0, 0, cur_left + 32'd1));
    send_cmd(make_cmd(CMD_SELECT, 1, 0, 0));
    // count of zero acts as one, above the maximum acts as the maximum
    wait_results_drained();
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(0));
    send_cmd(make_cmd(CMD_SELECT, 1, 0, 0));
    send_cmd(make_cmd(CMD_SELECT, 0, 0, 0));
    wait_results_drained();
    write_reg(REG_FRAME_COUNT, CFG_DATA_W'(31));
    send_cmd(make_cmd(CMD_SELECT, 15, 0, 0));
    send_cmd(make_cmd(CMD_TICK, 0, 0, 32'hFFFF_FFFF));
  endtask

  // Random beats over a series of frame counts and enable settings
  task automatic test_random_traffic();
    int                    phase;
    int                    fc_pick;
    int                    target;
    logic [CFG_DATA_W-1:0] en_word;
    phase      = 0;
    sent_items = 0;
    while (sent_items < 750) begin
      case (phase)
        0:       fc_pick = 16;
        1:       fc_pick = 1;
        2:       fc_pick = 5;
        3:       fc_pick = 0;
        4:       fc_pick = 31;
        5:       fc_pick = 16;
        6:       fc_pick = 3;
        7:       fc_pick = 9;
        default: fc_pick = $urandom_range(0, 31);
      endcase
      en_word = CFG_DATA_W'(($urandom_range(0, 15) << 1) | ((phase % 5 != 4) ? 1 : 0));
      wait_results_drained();
      write_reg(REG_FRAME_COUNT, CFG_DATA_W'(fc_pick));
      write_reg(REG_ANIM_EN, en_word);
      quiet  = (phase % 4 == 2);
      target = sent_items + 80;
      while (sent_items < target && sent_items < 750) begin
        if ($urandom_range(0, 59) == 0) wait_results_drained();
        if ($urandom_range(0, 99) == 0) quiet = !quiet;
        send_cmd(random_cmd());
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  // Response side: random stalls, compare each beat with the oldest prediction
  initial begin : rsp_side
    frame_view_t want;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (rsp_ch.valid && rsp_ch.ready) begin
          if (pending_views.size() == 0) begin
            report_mismatch("response beat with nothing pending");
          end else begin
            want = pending_views.pop_front();
            if (rsp_ch.visible_frame !== want.visible_frame)
              report_mismatch($sformatf("visible_frame exp %0d got %0d",
                                        want.visible_frame, rsp_ch.visible_frame));
            if (rsp_ch.time_left !== want.time_left)
              report_mismatch($sformatf("time_left exp %0d got %0d",
                                        want.time_left, rsp_ch.time_left));
            if (rsp_ch.frame_changed !== want.frame_changed)
              report_mismatch($sformatf("frame_changed exp %0d got %0d",
                                        want.frame_changed, rsp_ch.frame_changed));
          end
        end
        if (stall_left > 0) begin
          stall_left--;
          rsp_ch.ready <= 1'b0;
        end else begin
          rsp_ch.ready <= 1'b1;
          if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= '0;
    req_ch.frame_index <= '0;
    req_ch.delay_ms    <= '0;
    req_ch.elapsed_ms  <= '0;
    for (int i = 0; i < MAX_FRAMES; i++) delay_mem[i] = '0;
    cur_frame = '0;
    cur_left  = '0;
    fc_reg    = FC_W'(1);
    anim_on   = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_fill();
    test_directed_walks();
    test_random_traffic();
    wait_results_drained();
    repeat (25) @(posedge clk);
    if (mismatches == 0)
      $display("[animation_frame_timer] OK");
    else
      $display("[animation_frame_timer] ERROR");
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("[animation_frame_timer] ERROR");
    $finish;
  end

endmodule
